>>> src/qse_pkg.sv
`timescale 1ns / 1ps

package qse_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned SpeedW   = 48;
  localparam int unsigned AlphaW   = 17;
  localparam int unsigned WrapW    = 16;
  localparam int unsigned OffsetW  = 32;
  localparam int unsigned ChangeW  = 34;
  localparam int unsigned DiffW    = 50;
  localparam int unsigned ProdW    = 68;
  localparam int unsigned FracW    = 16;

  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  localparam logic [CountW-1:0] ReloadRst  = 16'd65535;
  localparam logic [AlphaW-1:0] AlphaRst   = 17'd6554;
  localparam logic [CountW-1:0] TimeoutRst = 16'd200;

  localparam logic signed [WrapW-1:0] WrapLimit = 16'sd32767;
  localparam logic [AlphaW-1:0]       OneQ16    = 17'd65536;
  localparam logic [ProdW-1:0]        HalfLsb   = 68'd32768;

  typedef enum logic [1:0] {
    REG_RELOAD  = 2'd0,
    REG_ALPHA   = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_WRAP   = 1'b1
  } op_e;

  typedef struct packed {
    logic [CountW-1:0] counter_reload;
    logic [AlphaW-1:0] lp_weight;
    logic [CountW-1:0] stop_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic                     reload_we;
    logic [CountW-1:0]        reload_wdata;
  } reload_wr_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic                     stopped;
    logic                     clear_counter;
  } res_t;

endpackage

>>> src/qse_cfg_regs.sv
`timescale 1ns / 1ps

module qse_cfg_regs import qse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output reload_wr_t        reload_wr_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_RELOAD:  cfg_d.counter_reload  = pwdata[CountW-1:0];
        REG_ALPHA:   cfg_d.lp_weight       = pwdata[AlphaW-1:0];
        REG_TIMEOUT: cfg_d.stop_timeout_ms = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RELOAD:  prdata = {{(PdataW-CountW){1'b0}}, cfg_q.counter_reload};
      REG_ALPHA:   prdata = {{(PdataW-AlphaW){1'b0}}, cfg_q.lp_weight};
      REG_TIMEOUT: prdata = {{(PdataW-CountW){1'b0}}, cfg_q.stop_timeout_ms};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counter_reload  <= ReloadRst;
      cfg_q.lp_weight       <= AlphaRst;
      cfg_q.stop_timeout_ms <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o                    = cfg_q;
  assign reload_wr_o.reload_we    = wr_en && (idx == REG_RELOAD);
  assign reload_wr_o.reload_wdata = pwdata[CountW-1:0];

endmodule

>>> src/qse_wrap_tracker.sv
`timescale 1ns / 1ps

// Keeps the saturating wrap count and its value in counts,
// wrap_count * (reload + 1), so the update path needs no multiply for the wraps.
module qse_wrap_tracker import qse_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wrap_i,
  input  logic                      down_i,
  input  logic                      clear_i,
  input  logic [CountW-1:0]         reload_i,
  input  reload_wr_t                reload_wr_i,
  output logic signed [OffsetW-1:0] offset_o
);

  logic signed [WrapW-1:0]   wrap_q, wrap_d;
  logic signed [OffsetW-1:0] offset_q, offset_d;
  logic signed [OffsetW-1:0] step;
  logic signed [OffsetW-1:0] rescaled;

  assign step     = $signed({{(OffsetW-CountW){1'b0}}, reload_i}) + 32'sd1;
  // The user makes reload changes only while idle, unchecked here; a write rescales the pending wraps to the new span.
  assign rescaled = OffsetW'($signed(wrap_q) *
                    ($signed({{(OffsetW-CountW){1'b0}}, reload_wr_i.reload_wdata})
                     + 32'sd1));

  always_comb begin
    wrap_d   = wrap_q;
    offset_d = offset_q;
    if (reload_wr_i.reload_we) begin
      offset_d = rescaled;
    end else if (clear_i) begin
      wrap_d   = '0;
      offset_d = '0;
    end else if (wrap_i) begin
      if (down_i) begin
        if (wrap_q > -WrapLimit) begin
          wrap_d   = wrap_q - 16'sd1;
          offset_d = offset_q - step;
        end
      end else begin
        if (wrap_q < WrapLimit) begin
          wrap_d   = wrap_q + 16'sd1;
          offset_d = offset_q + step;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q   <= '0;
      offset_q <= '0;
    end else begin
      wrap_q   <= wrap_d;
      offset_q <= offset_d;
    end
  end

  assign offset_o = offset_q;

endmodule

>>> src/qse_speed_update.sv
`timescale 1ns / 1ps

// Position change, stop timeout and the low-pass filter, one update per cycle.
module qse_speed_update import qse_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      update_i,
  input  logic [CountW-1:0]         count_i,
  input  logic [TimeW-1:0]          time_i,
  input  cfg_t                      cfg_i,
  input  logic signed [OffsetW-1:0] offset_i,
  output res_t                      res_o
);

  logic [CountW-1:0]        prev_count_q, prev_count_d;
  logic [TimeW-1:0]         last_move_q, last_move_d;
  logic signed [SpeedW-1:0] speed_q, speed_d;
  logic                     stopped_q, stopped_d;

  logic signed [ChangeW-1:0] change;
  logic [TimeW-1:0]          elapsed;
  logic                      idle_run, expire;
  logic [AlphaW-1:0]         alpha_eff;
  logic signed [DiffW-1:0]   diff;
  logic signed [ProdW-1:0]   prod, prod_rnd;
  logic signed [SpeedW-1:0]  speed_filt;

  assign change = $signed({{(ChangeW-CountW){1'b0}}, count_i})
                - $signed({{(ChangeW-CountW){1'b0}}, prev_count_q})
                + $signed({{(ChangeW-OffsetW){offset_i[OffsetW-1]}}, offset_i});

  assign elapsed  = time_i - last_move_q;
  assign idle_run = (change == '0) && !stopped_q;
  assign expire   = elapsed >= {{(TimeW-CountW){1'b0}}, cfg_i.stop_timeout_ms};

  // new = speed + round((x - speed) * alpha / 2^16), x = change in Q.16
  assign alpha_eff  = (cfg_i.lp_weight > OneQ16) ? OneQ16 : cfg_i.lp_weight;
  assign diff       = $signed({change, {FracW{1'b0}}})
                    - $signed({{(DiffW-SpeedW){speed_q[SpeedW-1]}}, speed_q});
  assign prod       = diff * $signed({1'b0, alpha_eff});
  assign prod_rnd   = prod + $signed(HalfLsb);
  assign speed_filt = speed_q + SpeedW'(prod_rnd >>> FracW);

  always_comb begin
    prev_count_d        = prev_count_q;
    last_move_d         = last_move_q;
    speed_d             = speed_q;
    stopped_d           = stopped_q;
    res_o.speed         = speed_q;
    res_o.stopped       = stopped_q;
    res_o.clear_counter = 1'b0;
    if (update_i) begin
      prev_count_d = count_i;
      if (idle_run) begin
        if (expire) begin
          prev_count_d        = '0;
          speed_d             = '0;
          stopped_d           = 1'b1;
          res_o.clear_counter = 1'b1;
        end
      end else begin
        stopped_d   = 1'b0;
        last_move_d = time_i;
        speed_d     = speed_filt;
      end
      res_o.speed   = speed_d;
      res_o.stopped = stopped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      last_move_q  <= '0;
      speed_q      <= '0;
      stopped_q    <= 1'b0;
    end else begin
      prev_count_q <= prev_count_d;
      last_move_q  <= last_move_d;
      speed_q      <= speed_d;
      stopped_q    <= stopped_d;
    end
  end

endmodule

>>> src/quadrature_speed_estimator_core.sv
`timescale 1ns / 1ps

// Quadrature encoder speed estimator. Each input transaction is either a
// counter wrap event (op = 1, direction on counting_down_i) or a periodic
// update (op = 0, counter value and millisecond time). Every transaction
// returns exactly one result: the filtered speed in counts per update
// (signed Q32.16), the stopped flag, and clear_counter, which pulses on the
// update that declares the encoder stopped and asks software or hardware to
// zero the counter. Throughput is one transaction per clock while out_stall_i
// is low, via an input register followed by a result register. While a result
// waits on out_stall_i the input register can still take one transaction,
// after that in_stall_o holds the input off. The clock rate is set
// by the filter loop: a 50 x 17 bit multiply, a round and an add feeding the
// speed register. Wraps are kept pre-scaled by reload+1, so the update path
// holds only that one multiply. Registers (APB, 32-bit data): 0x0
// counter_reload, 0x4 lp_weight (Q1.16, values above 1.0 act as 1.0),
// 0x8 stop_timeout_ms. Write them only while no transaction is in flight.
module quadrature_speed_estimator_core import qse_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PaddrW-1:0]        paddr,
  input  logic [PdataW-1:0]        pwdata,
  output logic [PdataW-1:0]        prdata,
  output logic                     pready,
  // event input
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [CountW-1:0]        count_value_i,
  input  logic [TimeW-1:0]         time_ms_i,
  input  logic                     counting_down_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [SpeedW-1:0] speed_o,
  output logic                     stopped_o,
  output logic                     clear_counter_o
);

  cfg_t       cfg;
  reload_wr_t reload_wr;

  // Input register
  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q;
  logic [CountW-1:0] s1_count_q;
  logic [TimeW-1:0]  s1_time_q;
  logic              s1_down_q;

  // Result register
  logic out_valid_q, out_valid_d;
  res_t res, out_q;

  logic out_load_ok;   // result register can take a new result
  logic s1_fire;       // input register hands its transaction on
  logic in_fire;       // new transaction captured

  logic signed [OffsetW-1:0] wrap_offset;

  qse_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .reload_wr_o (reload_wr)
  );

  assign out_load_ok = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && out_load_ok;
  assign in_stall_o  = s1_valid_q && !out_load_ok;
  assign in_fire     = in_valid_i && !in_stall_o;

  // Wrap events bump the count; any update consumes it.
  qse_wrap_tracker u_wrap_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wrap_i      (s1_fire && (s1_op_q == OP_WRAP)),
    .down_i      (s1_down_q),
    .clear_i     (s1_fire && (s1_op_q == OP_UPDATE)),
    .reload_i    (cfg.counter_reload),
    .reload_wr_i (reload_wr),
    .offset_o    (wrap_offset)
  );

  qse_speed_update u_speed_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (s1_fire && (s1_op_q == OP_UPDATE)),
    .count_i  (s1_count_q),
    .time_i   (s1_time_q),
    .cfg_i    (cfg),
    .offset_i (wrap_offset),
    .res_o    (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= op_e'(op_i);
      s1_count_q <= count_value_i;
      s1_time_q  <= time_ms_i;
      s1_down_q  <= counting_down_i;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_o         = out_q.speed;
  assign stopped_o       = out_q.stopped;
  assign clear_counter_o = out_q.clear_counter;

endmodule

>>> bench/quadrature_speed_estimator_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the encoder speed estimator. Each transaction
// moves through an in-bench speed estimate; each result is checked in order
// against it, or a typed row's want. The stimulus is a short directed script
// followed by random encoder motion under several register settings.
module quadrature_speed_estimator_core_tb;
  import qse_pkg::*;

  localparam int CycleLimit   = 100000;
  localparam int RxHoldCycles = 60;      // long receiver hold to back up the pipe
  localparam int DrainCycles  = 10;      // idle margin after the final drain
  localparam int MaxReports   = 10;
  localparam int BurstWraps   = 12;      // wraps per direction at full reload
  localparam bit TYPED        = 1'b1;
  localparam bit PREDICT      = 1'b0;

  typedef struct {
    op_e         op;
    logic [15:0] count;
    logic [31:0] stamp;
    logic        down;
  } event_t;

  // One directed step; want is used only when typed is set.
  typedef struct {
    event_t ev;
    bit     typed;
    res_t   want;
  } row_t;

  // ---------------------------------------------------------------------
  // DUT connections; every input starts at a known value.
  // ---------------------------------------------------------------------
  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     psel            = 1'b0;
  logic                     penable         = 1'b0;
  logic                     pwrite          = 1'b0;
  logic [PaddrW-1:0]        paddr           = '0;
  logic [PdataW-1:0]        pwdata          = '0;
  logic [PdataW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic                     op_i            = 1'b0;
  logic [CountW-1:0]        count_value_i   = '0;
  logic [TimeW-1:0]         time_ms_i       = '0;
  logic                     counting_down_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic signed [SpeedW-1:0] speed_o;
  logic                     stopped_o;
  logic                     clear_counter_o;

  quadrature_speed_estimator_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .count_value_i   (count_value_i),
    .time_ms_i       (time_ms_i),
    .counting_down_i (counting_down_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_o         (speed_o),
    .stopped_o       (stopped_o),
    .clear_counter_o (clear_counter_o)
  );

  // ---------------------------------------------------------------------
  // Estimator state as the bench sees it, plus its register copies.
  // ---------------------------------------------------------------------
  logic [15:0]        est_prev_count = '0;
  int                 est_wraps      = 0;
  logic [31:0]        est_last_move  = '0;
  logic signed [47:0] est_speed      = '0;
  logic               est_stopped    = 1'b0;
  logic [15:0]        cfg_reload     = ReloadRst;
  logic [16:0]        cfg_alpha      = AlphaRst;
  logic [15:0]        cfg_timeout    = TimeoutRst;

  res_t        speed_q[$];   // results still owed by the DUT, oldest first
  logic [31:0] cur_time = '0;
  bit          idling_on = 1'b1;
  bit          rx_hold_req = 1'b0;
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          stops_declared = 0;
  int          settings_applied = 0;
  int          cycle_count = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the DUT hangs a handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               speed_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Next state and result for one transaction. Update events compute the
  // position change including whole wraps, then either run the stop timer
  // (zero change while running) or feed the low-pass filter. The filter
  // product is carried at 80 bits so nothing overflows before the round.
  function automatic res_t estimate_speed(event_t ev);
    longint             delta;
    longint             x;
    longint             a;
    logic signed [79:0] mix;
    logic [31:0]        elapsed;
    res_t               r;
    r.clear_counter = 1'b0;
    if (ev.op == OP_WRAP) begin
      if (ev.down) begin
        if (est_wraps > -int'(WrapLimit)) est_wraps--;
      end else if (est_wraps < int'(WrapLimit)) begin
        est_wraps++;
      end
    end else begin
      delta = longint'(ev.count) - longint'(est_prev_count)
            + longint'(est_wraps) * (longint'(cfg_reload) + 1);
      est_wraps      = 0;
      est_prev_count = ev.count;
      elapsed        = ev.stamp - est_last_move;  // modulo 2^32 on purpose
      if (delta == 0 && !est_stopped) begin
        if (elapsed >= {16'd0, cfg_timeout}) begin
          est_prev_count  = '0;
          est_speed       = '0;
          est_stopped     = 1'b1;
          r.clear_counter = 1'b1;
          stops_declared++;
        end
      end else begin
        // Any change, or a zero change while stopped, counts as movement.
        est_stopped   = 1'b0;
        est_last_move = ev.stamp;
        a   = (cfg_alpha > 17'd65536) ? 64'sd65536 : longint'(cfg_alpha);
        x   = delta * 65536;
        mix = est_speed * (65536 - a) + x * a;
        est_speed = 48'((mix + 80'sd32768) >>> 16);  // round half up
      end
    end
    r.speed   = est_speed;
    r.stopped = est_stopped;
    return r;
  endfunction

  // APB write, then read back and compare against the masked value.
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] readback;
    mask = (idx == REG_ALPHA) ? 32'h0001_FFFF : 32'h0000_FFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    readback = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_RELOAD:  cfg_reload  = value[15:0];
      REG_ALPHA:   cfg_alpha   = value[16:0];
      default:     cfg_timeout = value[15:0];
    endcase
    if (readback !== (value & mask)) begin
      if (errors < MaxReports)
        $display("register %s readback: expected %h, actual %h", idx.name(),
                 value & mask, readback);
      errors++;
    end
  endtask

  task automatic apply_settings(logic [31:0] reload, logic [31:0] alpha,
                                logic [31:0] timeout);
    write_reg(REG_RELOAD, reload);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_TIMEOUT, timeout);
    settings_applied++;
  endtask

  // Offer one transaction; called at a rising edge, returns at the edge
  // where it was taken. The expectation is queued once acceptance is sure.
  task automatic send_event(event_t ev, bit use_typed = 1'b0, res_t typed_res = '0);
    res_t predicted;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= ev.op;
    count_value_i   <= ev.count;
    time_ms_i       <= ev.stamp;
    counting_down_i <= ev.down;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    predicted = estimate_speed(ev);
    speed_q.push_back(use_typed ? typed_res : predicted);
    @(posedge clk_i);
    sent++;
  endtask

  // Sender goes quiet until every owed result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (speed_q.size() != 0) @(posedge clk_i);
  endtask

  // Random motion. Mostly plausible encoder traffic: moves with a few
  // wraps in front, standstill runs long enough to trip the stop timer,
  // time jumps across the 32-bit wrap, and some fully random noise.
  task automatic run_random(int n_items);
    int     left;
    int     kind;
    event_t ev;
    left = n_items;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        if ($urandom_range(0, 2) == 0) begin
          ev.op   = OP_WRAP;
          ev.down = $urandom_range(0, 1);
          repeat ($urandom_range(1, 3)) begin
            ev.count = $urandom;
            ev.stamp = $urandom;
            send_event(ev);
            left--;
          end
        end
        ev.op = OP_UPDATE;
        if ($urandom_range(0, 7) == 0) ev.count = $urandom;
        else ev.count = est_prev_count + 16'($urandom_range(0, 600)) - 16'd300;
        cur_time += $urandom_range(1, 40);
        ev.stamp  = cur_time;
        ev.down   = $urandom_range(0, 1);
        send_event(ev);
        left--;
      end else if (kind <= 7) begin
        // standstill: same count, time creeping forward
        repeat ($urandom_range(2, 12)) begin
          ev.op    = OP_UPDATE;
          ev.count = est_prev_count;
          cur_time += ($urandom_range(0, 9) == 0) ? $urandom_range(100, 5000)
                                                 : $urandom_range(1, 60);
          ev.stamp = cur_time;
          ev.down  = $urandom_range(0, 1);
          send_event(ev);
          left--;
        end
      end else if (kind == 8) begin
        cur_time = $urandom;
        ev.op    = OP_UPDATE;
        ev.count = est_prev_count;
        ev.stamp = cur_time;
        ev.down  = $urandom_range(0, 1);
        send_event(ev);
        left--;
      end else begin
        ev.op    = op_e'($urandom_range(0, 1));
        ev.count = $urandom;
        ev.stamp = $urandom;
        ev.down  = $urandom_range(0, 1);
        send_event(ev);
        left--;
      end
    end
  endtask

  function automatic row_t mk_row(op_e op, logic [15:0] count, logic [31:0] stamp,
                                  logic down, bit typed, logic signed [47:0] spd = '0,
                                  logic stp = 1'b0, logic clr = 1'b0);
    row_t r;
    r.ev.op    = op;
    r.ev.count = count;
    r.ev.stamp = stamp;
    r.ev.down  = down;
    r.typed    = typed;
    r.want.speed         = spd;
    r.want.stopped       = stp;
    r.want.clear_counter = clr;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts while idling is on, one long counted
  // hold on request, and a free-flowing output otherwise.
  // ---------------------------------------------------------------------
  initial begin
    int held;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < RxHoldCycles; held++) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker. Sampled at the falling edge, so the values are the
  // ones the next rising edge transfers.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (speed_q.size() == 0) begin
        if (errors < MaxReports)
          $display("unexpected result: speed %0d stopped %b clear %b", speed_o,
                   stopped_o, clear_counter_o);
        errors++;
      end else begin
        want = speed_q.pop_front();
        checked++;
        if (speed_o !== want.speed || stopped_o !== want.stopped ||
            clear_counter_o !== want.clear_counter) begin
          if (errors < MaxReports)
            $display("result %0d: expected speed %0d stopped %b clear %b, ",
                     checked, want.speed, want.stopped, want.clear_counter,
                     "actual speed %0d stopped %b clear %b",
                     speed_o, stopped_o, clear_counter_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    row_t   script[$];
    event_t ev;

    // Directed script under reset settings (reload 65535, alpha 6554,
    // timeout 200). Rows with a typed result are ones where the speed is
    // plainly zero: reset, stop declarations, standstill, restart, wraps.
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'd0,   1'b0, TYPED));
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'd199, 1'b0, TYPED));  // one ms short
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'd200, 1'b0, TYPED, '0, 1'b1, 1'b1));
    // zero change while stopped restarts with a zero sample
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'd201, 1'b0, TYPED));
    script.push_back(mk_row(OP_WRAP,   16'hFFFF, 32'hFFFF_FFFF, 1'b0, TYPED));
    script.push_back(mk_row(OP_WRAP,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, TYPED));
    script.push_back(mk_row(OP_UPDATE, 16'hFFFF, 32'd202, 1'b1, PREDICT));
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'd203, 1'b1, PREDICT));
    script.push_back(mk_row(OP_WRAP,   16'h0000, 32'd0,   1'b0, PREDICT));
    script.push_back(mk_row(OP_WRAP,   16'h0000, 32'd0,   1'b0, PREDICT));
    script.push_back(mk_row(OP_UPDATE, 16'h0001, 32'd204, 1'b0, PREDICT));
    script.push_back(mk_row(OP_WRAP,   16'h0000, 32'd0,   1'b1, PREDICT));
    script.push_back(mk_row(OP_UPDATE, 16'h0001, 32'd205, 1'b0, PREDICT));
    // long standstill just below the time wrap, then elapsed time across it
    script.push_back(mk_row(OP_UPDATE, 16'h0001, 32'hFFFF_FFF0, 1'b0, TYPED, '0, 1'b1, 1'b1));
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'hFFFF_FFF8, 1'b0, TYPED));
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'h0000_0010, 1'b0, TYPED));
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'h0000_00BF, 1'b0, TYPED));
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'h0000_00C0, 1'b0, TYPED, '0, 1'b1, 1'b1));
    script.push_back(mk_row(OP_WRAP,   16'h0000, 32'h0000_0000, 1'b0, TYPED, '0, 1'b1, 1'b0));
    script.push_back(mk_row(OP_UPDATE, 16'h0000, 32'h0000_00C1, 1'b0, PREDICT));
    script.push_back(mk_row(OP_UPDATE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, PREDICT));
    script.push_back(mk_row(OP_WRAP,   16'h0000, 32'h0000_0000, 1'b1, PREDICT));
    script.push_back(mk_row(OP_UPDATE, 16'h8000, 32'h8000_0000, 1'b1, PREDICT));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);
    drain();

    // Low extremes: one count per wrap, frozen filter, 1 ms timeout.
    apply_settings(32'd0, 32'd0, 32'd1);
    cur_time = $urandom;
    run_random(100);
    drain();

    // High extremes: full reload and alpha at one, with wrap bursts in
    // both directions ahead of an update each.
    apply_settings(32'd65535, 32'd65536, 32'd65535);
    idling_on = 1'b0;
    ev.op    = OP_WRAP;
    ev.count = '0;
    ev.stamp = '0;
    ev.down  = 1'b0;
    repeat (BurstWraps) send_event(ev);
    ev.op    = OP_UPDATE;
    cur_time += 1;
    ev.stamp = cur_time;
    send_event(ev);
    ev.op   = OP_WRAP;
    ev.down = 1'b1;
    repeat (BurstWraps) send_event(ev);
    ev.op    = OP_UPDATE;
    ev.count = 16'hFFFF;
    cur_time += 1;
    ev.stamp = cur_time;
    send_event(ev);
    // Back-pressure: sender streams while the receiver holds off.
    rx_hold_req = 1'b1;
    run_random(40);
    idling_on = 1'b1;
    run_random(60);
    drain();

    // Alpha above one, zero timeout, random reload.
    apply_settings($urandom_range(0, 65535), 32'd131071, 32'd0);
    run_random(100);
    drain();

    // Random mid-range settings.
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65536),
                   $urandom_range(1, 300));
    run_random(100);
    drain();
    apply_settings($urandom_range(0, 65535), $urandom_range(65537, 131071),
                   $urandom_range(1, 300));
    run_random(100);
    drain();

    // Back to reset values; final stretch with no idling on either side.
    apply_settings({16'd0, ReloadRst}, {15'd0, AlphaRst}, {16'd0, TimeoutRst});
    idling_on = 1'b0;
    run_random(100);
    drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d transactions sent, %0d results checked, %0d stop declarations",
             sent, checked, stops_declared);
    $display("%0d register settings applied, wrap bursts both ways at full reload",
             settings_applied);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/qse_pkg.sv
src/qse_cfg_regs.sv
src/qse_wrap_tracker.sv
src/qse_speed_update.sv
src/quadrature_speed_estimator_core.sv
bench/quadrature_speed_estimator_core_tb.sv
